>>> rtl/gfcb_pkg.sv
package gfcb_pkg;

    // Default array limits of the frame store.
    localparam int DEF_MAX_ROWS   = 256;
    localparam int DEF_MAX_COLS   = 256;
    localparam int DEF_MAX_RADIUS = 4;

    // Field widths fixed by the interface.
    localparam int PIX_W       = 8;
    localparam int POS_W       = 8;
    localparam int WEIGHT_W    = 16;
    localparam int NUM_WEIGHTS = 5;
    localparam int WIDX_W      = $clog2(NUM_WEIGHTS);

    // Rounding of the window sum, a fixed-point value with 32 fraction bits (Q16.32 at the default radius).
    localparam int FRAC_W = 32;

    // Operation codes of an input transaction.
    localparam logic OP_STORE  = 1'b0;
    localparam logic OP_FILTER = 1'b1;

    // Register reset values.
    localparam logic [8:0]  RST_ROWS   = 9'd256;
    localparam logic [8:0]  RST_COLS   = 9'd256;
    localparam logic [2:0]  RST_RADIUS = 3'd1;
    localparam logic [WEIGHT_W-1:0] RST_W0 = 16'd26145;
    localparam logic [WEIGHT_W-1:0] RST_W1 = 16'd15857;
    localparam logic [WEIGHT_W-1:0] RST_W2 = 16'd3538;
    localparam logic [WEIGHT_W-1:0] RST_W3 = 16'd290;
    localparam logic [WEIGHT_W-1:0] RST_W4 = 16'd9;

    typedef logic [NUM_WEIGHTS-1:0][WEIGHT_W-1:0] t_weights;

    // Control that travels with each window read through the accumulator.
    typedef struct packed {
        logic                valid;
        logic                eol;
        logic                last;
        logic [WEIGHT_W-1:0] wj;
        logic [WEIGHT_W-1:0] wi;
    } t_mac_ctrl;

    // Weight of a window offset magnitude; offsets without a register weigh zero.
    function automatic logic [WEIGHT_W-1:0] weight_sel(t_weights w, logic [3:0] a);
        logic [WEIGHT_W-1:0] res;
        res = '0;
        if (a < 4'(NUM_WEIGHTS)) begin
            res = w[a[WIDX_W-1:0]];
        end
        return res;
    endfunction

endpackage

>>> rtl/gfcb_frame_mem.sv
module gfcb_frame_mem
    import gfcb_pkg::*;
#(
    parameter int ADDR_W = 16
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [PIX_W-1:0]  i_wdata,
    output logic [PIX_W-1:0]  o_rdata
);

    logic [PIX_W-1:0] r_mem [2**ADDR_W];
    logic [PIX_W-1:0] r_rdata;

    // Single port: a write or a registered read in each cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/gfcb_seq.sv
module gfcb_seq
    import gfcb_pkg::*;
#(
    parameter int MAX_ROWS   = DEF_MAX_ROWS,
    parameter int MAX_COLS   = DEF_MAX_COLS,
    parameter int MAX_RADIUS = DEF_MAX_RADIUS,
    localparam int RW  = $clog2(MAX_ROWS),
    localparam int CW  = $clog2(MAX_COLS),
    localparam int NRW = $clog2(MAX_ROWS + 1),
    localparam int NCW = $clog2(MAX_COLS + 1),
    localparam int RDW = $clog2(MAX_RADIUS + 1)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [POS_W-1:0] i_row,
    input  logic [POS_W-1:0] i_col,
    input  logic [RDW-1:0] i_radius,
    input  logic [NRW-1:0] i_rows,
    input  logic [NCW-1:0] i_cols,
    input  t_weights       i_weights,
    output logic [RW+CW-1:0] o_rd_addr,
    output t_mac_ctrl      o_ctrl
);

    localparam int DW  = RDW + 1;
    localparam int MW0 = (POS_W > RW + 1) ? POS_W : RW + 1;
    localparam int MW1 = (MW0 > CW + 1) ? MW0 : CW + 1;
    localparam int PW  = MW1 + 2;

    logic                   r_busy;
    logic signed [DW-1:0]   r_di;
    logic signed [DW-1:0]   r_dj;
    logic [RDW-1:0]         r_rad;
    logic [POS_W-1:0]       r_row;
    logic [POS_W-1:0]       r_col;

    logic signed [DW-1:0]   rad_s;
    logic signed [DW-1:0]   start_off;
    logic [DW-1:0]          abs_di;
    logic [DW-1:0]          abs_dj;
    logic signed [PW-1:0]   pos_r;
    logic signed [PW-1:0]   pos_c;
    logic signed [PW-1:0]   lim_r;
    logic signed [PW-1:0]   lim_c;
    logic signed [PW-1:0]   clp_r;
    logic signed [PW-1:0]   clp_c;

    assign rad_s     = $signed(DW'(r_rad));
    assign start_off = -$signed(DW'(i_radius));

    // Walk the window row by row, one pixel read per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_di   <= start_off;
            r_dj   <= start_off;
            r_rad  <= i_radius;
            r_row  <= i_row;
            r_col  <= i_col;
        end else if (r_busy) begin
            if (r_dj == rad_s) begin
                r_dj <= -rad_s;
                if (r_di == rad_s) begin
                    r_busy <= 1'b0;
                end else begin
                    r_di <= r_di + DW'(1);
                end
            end else begin
                r_dj <= r_dj + DW'(1);
            end
        end
    end

    // Clamp each window position to the frame on its own.
    always_comb begin
        pos_r = $signed(PW'(r_row)) + PW'(r_di);
        pos_c = $signed(PW'(r_col)) + PW'(r_dj);
        lim_r = $signed(PW'(i_rows));
        lim_c = $signed(PW'(i_cols));
        if (pos_r < 0) begin
            clp_r = '0;
        end else if (pos_r >= lim_r) begin
            clp_r = lim_r - PW'(1);
        end else begin
            clp_r = pos_r;
        end
        if (pos_c < 0) begin
            clp_c = '0;
        end else if (pos_c >= lim_c) begin
            clp_c = lim_c - PW'(1);
        end else begin
            clp_c = pos_c;
        end
    end

    assign o_rd_addr = {clp_r[RW-1:0], clp_c[CW-1:0]};

    // Weights and row markers for the read issued this cycle.
    assign abs_di = (r_di < 0) ? DW'(-r_di) : DW'(r_di);
    assign abs_dj = (r_dj < 0) ? DW'(-r_dj) : DW'(r_dj);

    always_comb begin
        o_ctrl       = '0;
        o_ctrl.valid = r_busy;
        o_ctrl.eol   = (r_dj == rad_s);
        o_ctrl.last  = (r_dj == rad_s) && (r_di == rad_s);
        o_ctrl.wj    = weight_sel(i_weights, 4'(abs_dj));
        o_ctrl.wi    = weight_sel(i_weights, 4'(abs_di));
    end

endmodule

>>> rtl/gfcb_mac.sv
module gfcb_mac
    import gfcb_pkg::*;
#(
    parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_mac_ctrl        i_ctrl,
    input  logic [PIX_W-1:0] i_rdata,
    output logic             o_res_valid,
    output logic [PIX_W-1:0] o_res
);

    localparam int TAPS = 2 * MAX_RADIUS + 1;
    localparam int PRW  = PIX_W + WEIGHT_W;
    localparam int LW   = PRW + $clog2(TAPS);
    localparam int QW   = LW + WEIGHT_W;
    localparam int AW   = QW + $clog2(TAPS);

    t_mac_ctrl         r_s1;
    t_mac_ctrl         r_s2;
    logic [PRW-1:0]    r_s2_prod;
    logic              r_s3_valid;
    logic              r_s3_last;
    logic [WEIGHT_W-1:0] r_s3_wi;
    logic [LW-1:0]     r_s3_line;
    logic [LW-1:0]     r_line;
    logic              r_s4_valid;
    logic              r_s4_last;
    logic [QW-1:0]     r_s4_prod;
    logic [AW-1:0]     r_acc;
    logic              r_fin_valid;
    logic [AW-1:0]     r_fin;

    logic [LW-1:0]     line_sum;
    logic [AW-1:0]     acc_sum;
    logic [AW:0]       rounded;
    logic [AW-FRAC_W:0] whole;

    assign line_sum = r_line + LW'(r_s2_prod);
    assign acc_sum  = r_acc + AW'(r_s4_prod);

    // Stage valids, markers and the control that travels with each read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid  <= 1'b0;
            r_s2.valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_fin_valid <= 1'b0;
            r_line      <= '0;
            r_acc       <= '0;
        end else begin
            r_s1        <= i_ctrl;
            r_s2        <= r_s1;
            r_s3_valid  <= r_s2.valid && r_s2.eol;
            r_s4_valid  <= r_s3_valid;
            r_fin_valid <= r_s4_valid && r_s4_last;
            // Line sum of one window row.
            if (r_s2.valid) begin
                r_line <= r_s2.eol ? '0 : line_sum;
            end
            // Window sum over all rows.
            if (r_s4_valid) begin
                r_acc <= r_s4_last ? '0 : acc_sum;
            end
        end
    end

    // Payload stages: pixel times column weight, then line times row weight.
    always_ff @(posedge i_clk) begin
        r_s2_prod <= PRW'(i_rdata) * PRW'(r_s1.wj);
        r_s3_line <= line_sum;
        r_s3_wi   <= r_s2.wi;
        r_s3_last <= r_s2.last;
        r_s4_prod <= QW'(r_s3_line) * QW'(r_s3_wi);
        r_s4_last <= r_s3_last;
        r_fin     <= acc_sum;
    end

    // Round half up to an integer and saturate.
    assign rounded = (AW + 1)'(r_fin) + ((AW + 1)'(1) << (FRAC_W - 1));
    assign whole   = rounded[AW:FRAC_W];

    assign o_res_valid = r_fin_valid;
    assign o_res       = (whole > (AW - FRAC_W + 1)'(255)) ? 8'd255 : whole[PIX_W-1:0];

endmodule

>>> rtl/gaussian_filter_clamped_border.sv
// A store in the array is written to memory once accepted. A filter reads each
// pixel of its window; no new transaction is taken until its result is in the
// output register. Throughput: one store per cycle while no filter is running;
// filters are paced by the memory's single read port, one window pixel per cycle.
// Reset is synchronous and active low: registers return to their defaults, the
// frame memory keeps its contents and is undefined until written.
module gaussian_filter_clamped_border
    import gfcb_pkg::*;
#(
    parameter int MAX_ROWS   = DEF_MAX_ROWS,
    parameter int MAX_COLS   = DEF_MAX_COLS,
    parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_op,
    input  logic [POS_W-1:0] i_row,
    input  logic [POS_W-1:0] i_col,
    input  logic [PIX_W-1:0] i_pixel_in,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [PIX_W-1:0] o_filtered,
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_idx,
    input  logic [15:0]      i_cfg_data
);

    localparam int RW  = $clog2(MAX_ROWS);
    localparam int CW  = $clog2(MAX_COLS);
    localparam int NRW = $clog2(MAX_ROWS + 1);
    localparam int NCW = $clog2(MAX_COLS + 1);
    localparam int RDW = $clog2(MAX_RADIUS + 1);

    typedef enum logic [2:0] {
        CFG_ROWS, CFG_COLS, CFG_RADIUS, CFG_W0, CFG_W1, CFG_W2, CFG_W3, CFG_W4
    } t_cfg_idx;

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} t_state;

    t_state           r_state;
    logic             r_out_valid;
    logic [PIX_W-1:0] r_out;
    logic [PIX_W-1:0] r_res;
    logic [8:0]       r_rows;
    logic [8:0]       r_cols;
    logic [2:0]       r_radius;
    t_weights         r_weights;

    logic             in_acc;
    logic             start;
    logic             store_ok;
    logic             mem_we;
    logic [RW+CW-1:0] wr_addr;
    logic [RW+CW-1:0] rd_addr;
    logic [PIX_W-1:0] rdata;
    logic [NRW-1:0]   rows_eff;
    logic [NCW-1:0]   cols_eff;
    logic [RDW-1:0]   rad_eff;
    t_mac_ctrl        ctrl;
    logic             res_valid;
    logic [PIX_W-1:0] res;
    logic             out_free;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows       <= RST_ROWS;
            r_cols       <= RST_COLS;
            r_radius     <= RST_RADIUS;
            r_weights[0] <= RST_W0;
            r_weights[1] <= RST_W1;
            r_weights[2] <= RST_W2;
            r_weights[3] <= RST_W3;
            r_weights[4] <= RST_W4;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ROWS:   r_rows       <= i_cfg_data[8:0];
                CFG_COLS:   r_cols       <= i_cfg_data[8:0];
                CFG_RADIUS: r_radius     <= i_cfg_data[2:0];
                CFG_W0:     r_weights[0] <= i_cfg_data;
                CFG_W1:     r_weights[1] <= i_cfg_data;
                CFG_W2:     r_weights[2] <= i_cfg_data;
                CFG_W3:     r_weights[3] <= i_cfg_data;
                CFG_W4:     r_weights[4] <= i_cfg_data;
                default:    r_rows       <= r_rows;
            endcase
        end
    end

    // Zero size acts as one; oversize sizes and radius act as their maximum.
    always_comb begin
        if (r_rows == '0) begin
            rows_eff = NRW'(1);
        end else if (32'(r_rows) > 32'(MAX_ROWS)) begin
            rows_eff = NRW'(MAX_ROWS);
        end else begin
            rows_eff = NRW'(r_rows);
        end
        if (r_cols == '0) begin
            cols_eff = NCW'(1);
        end else if (32'(r_cols) > 32'(MAX_COLS)) begin
            cols_eff = NCW'(MAX_COLS);
        end else begin
            cols_eff = NCW'(r_cols);
        end
        if (32'(r_radius) > 32'(MAX_RADIUS)) begin
            rad_eff = RDW'(MAX_RADIUS);
        end else begin
            rad_eff = RDW'(r_radius);
        end
    end

    // Input handshake; stores outside the array are dropped.
    assign o_in_ready = (r_state == ST_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign start      = in_acc && (i_op == OP_FILTER);
    assign store_ok   = (32'(i_row) < 32'(MAX_ROWS)) && (32'(i_col) < 32'(MAX_COLS));
    assign mem_we     = in_acc && (i_op == OP_STORE) && store_ok;
    assign wr_addr    = {RW'(i_row), CW'(i_col)};

    gfcb_frame_mem #(
        .ADDR_W (RW + CW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_we ? wr_addr : rd_addr),
        .i_wdata (i_pixel_in),
        .o_rdata (rdata)
    );

    gfcb_seq #(
        .MAX_ROWS   (MAX_ROWS),
        .MAX_COLS   (MAX_COLS),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_row     (i_row),
        .i_col     (i_col),
        .i_radius  (rad_eff),
        .i_rows    (rows_eff),
        .i_cols    (cols_eff),
        .i_weights (r_weights),
        .o_rd_addr (rd_addr),
        .o_ctrl    (ctrl)
    );

    gfcb_mac #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .i_rdata     (rdata),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Output register frees itself when the current transaction is taken.
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (start) begin
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (res_valid) begin
                        if (out_free) begin
                            r_out       <= res;
                            r_out_valid <= 1'b1;
                            r_state     <= ST_IDLE;
                        end else begin
                            r_res   <= res;
                            r_state <= ST_DONE;
                        end
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_filtered  = r_out;

endmodule

>>> rtl/gfcb_checker.sv
module gfcb_checker
    import gfcb_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_ready,
    input logic             i_op,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input logic [PIX_W-1:0] o_filtered
);

    // A result waiting to be taken keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_filtered))
        else $error("result changed while stalled");

    // Reset empties the output register.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A filter transaction occupies the block.
    a_filter_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_op == OP_FILTER) |=> !o_in_ready)
        else $error("input taken during a filter");

    // A store transaction completes at once.
    a_store_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_op == OP_STORE) |=> o_in_ready)
        else $error("store held the input");

    // No result can be raised in the cycle after a filter starts.
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_op == OP_FILTER) |=> !$rose(o_out_valid))
        else $error("result raised too early");

endmodule

bind gaussian_filter_clamped_border gfcb_checker u_gfcb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_op        (i_op),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_filtered  (o_filtered)
);

>>> sim/gaussian_filter_clamped_border_tb.sv
module gaussian_filter_clamped_border_tb;

    import gfcb_pkg::*;

    // Register indexes of the configuration port.
    localparam logic [2:0] REG_ROWS   = 3'd0;
    localparam logic [2:0] REG_COLS   = 3'd1;
    localparam logic [2:0] REG_RADIUS = 3'd2;
    localparam logic [2:0] REG_W0     = 3'd3;

    localparam int STRIDE          = DEF_MAX_COLS;
    localparam int NUM_PHASES      = 12;
    localparam int ITEMS_PER_PHASE = 20;
    localparam int SETTLE_CYCLES   = 100;
    localparam int HOLD_CYCLES     = 600;
    localparam int PAUSE_PHASE     = 6;
    localparam int HOLD_PHASE      = 9;

    typedef struct packed {
        logic             op;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic [PIX_W-1:0] pix;
    } t_pix_req;

    logic             i_clk      = 1'b0;
    logic             i_rst_n    = 1'b0;
    logic             i_in_valid = 1'b0;
    logic             o_in_ready;
    logic             i_op       = OP_STORE;
    logic [POS_W-1:0] i_row      = '0;
    logic [POS_W-1:0] i_col      = '0;
    logic [PIX_W-1:0] i_pixel_in = '0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    logic [PIX_W-1:0] o_filtered;
    logic             i_cfg_we   = 1'b0;
    logic [2:0]       i_cfg_idx  = '0;
    logic [15:0]      i_cfg_data = '0;

    // Shadow copy of the configuration registers.
    logic [8:0] sh_rows    = RST_ROWS;
    logic [8:0] sh_cols    = RST_COLS;
    logic [2:0] sh_radius  = RST_RADIUS;
    t_weights   sh_weights = {RST_W4, RST_W3, RST_W2, RST_W1, RST_W0};

    // Frame contents as the block sees them, and pixels already queued for writing.
    logic [PIX_W-1:0] frame_model [0:DEF_MAX_ROWS*DEF_MAX_COLS-1];
    bit               queued_written [0:DEF_MAX_ROWS*DEF_MAX_COLS-1];
    logic [15:0]      stored_pos [$];

    t_pix_req         pending_reqs [$];
    logic [PIX_W-1:0] expected_pixels [$];

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    bit hold_toggle = 1'b0;
    bit hold_seen   = 1'b0;
    int stall_left  = 0;
    int errors      = 0;
    int results_checked = 0;
    int stores_done  = 0;
    int filters_done = 0;
    int settings_used = 1;

    gaussian_filter_clamped_border u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_op        (i_op),
        .i_row       (i_row),
        .i_col       (i_col),
        .i_pixel_in  (i_pixel_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_filtered  (o_filtered),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    // Free-running clock.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Frame size as the block applies it: zero acts as one, oversize as the maximum.
    function automatic int eff_size(input logic [8:0] v);
        int res;
        res = int'(v);
        if (res == 0) begin
            res = 1;
        end else if (res > DEF_MAX_ROWS) begin
            res = DEF_MAX_ROWS;
        end
        return res;
    endfunction

    function automatic int eff_radius();
        return (sh_radius > 3'(DEF_MAX_RADIUS)) ? DEF_MAX_RADIUS : int'(sh_radius);
    endfunction

    function automatic int clamp_pos(input int p, input int n);
        int res;
        res = p;
        if (p < 0) begin
            res = 0;
        end else if (p >= n) begin
            res = n - 1;
        end
        return res;
    endfunction

    function automatic logic [63:0] weight_of(input int off);
        int a;
        logic [63:0] res;
        a = (off < 0) ? -off : off;
        res = '0;
        if (a < NUM_WEIGHTS) begin
            res = 64'(sh_weights[a]);
        end
        return res;
    endfunction

    // Rounded, saturated Gaussian sum over the clamped window around (row, col).
    function automatic logic [PIX_W-1:0] blur_at(input logic [POS_W-1:0] row,
                                                 input logic [POS_W-1:0] col);
        int nr, nc, r, di, dj, pr, pc;
        logic [63:0] acc, line, rounded;
        nr = eff_size(sh_rows);
        nc = eff_size(sh_cols);
        r = eff_radius();
        acc = '0;
        for (di = -r; di <= r; di++) begin
            pr = clamp_pos(int'(row) + di, nr);
            line = '0;
            for (dj = -r; dj <= r; dj++) begin
                pc = clamp_pos(int'(col) + dj, nc);
                line += weight_of(dj) * 64'(frame_model[pr * STRIDE + pc]);
            end
            acc += line * weight_of(di);
        end
        rounded = (acc + (64'd1 << (FRAC_W - 1))) >> FRAC_W;
        return (rounded > 64'd255) ? 8'hFF : rounded[PIX_W-1:0];
    endfunction

    // A filter may only be requested once every pixel its window reads has been written.
    function automatic bit window_ready(input int row, input int col);
        int nr, nc, r, di, dj;
        bit ok;
        nr = eff_size(sh_rows);
        nc = eff_size(sh_cols);
        r = eff_radius();
        ok = 1'b1;
        for (di = -r; di <= r; di++) begin
            for (dj = -r; dj <= r; dj++) begin
                if (!queued_written[clamp_pos(row + di, nr) * STRIDE
                                    + clamp_pos(col + dj, nc)]) begin
                    ok = 1'b0;
                end
            end
        end
        return ok;
    endfunction

    task automatic push_req(input logic op, input int row, input int col, input int pix);
        t_pix_req req;
        req.op  = op;
        req.row = POS_W'(row);
        req.col = POS_W'(col);
        req.pix = PIX_W'(pix);
        pending_reqs.push_back(req);
        if (op == OP_STORE) begin
            queued_written[int'(req.row) * STRIDE + int'(req.col)] = 1'b1;
            stored_pos.push_back({req.row, req.col});
        end
    endtask

    // Wait until every transaction has been accepted and every result has arrived.
    task automatic wait_drained();
        do begin
            @(negedge i_clk);
        end while (pending_reqs.size() != 0 || i_in_valid || expected_pixels.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Write all registers, one per clock, with random bits above the width of the size and radius registers.
    task automatic configure_block(input logic [8:0] rows, input logic [8:0] cols,
                                   input logic [2:0] rad, input t_weights w);
        int k;
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_ROWS;
        i_cfg_data <= {7'($urandom), rows};
        sh_rows    = rows;
        @(posedge i_clk);
        i_cfg_idx  <= REG_COLS;
        i_cfg_data <= {7'($urandom), cols};
        sh_cols    = cols;
        @(posedge i_clk);
        i_cfg_idx  <= REG_RADIUS;
        i_cfg_data <= {13'($urandom), rad};
        sh_radius  = rad;
        for (k = 0; k < NUM_WEIGHTS; k++) begin
            @(posedge i_clk);
            i_cfg_idx  <= REG_W0 + 3'(k);
            i_cfg_data <= w[k];
            sh_weights[k] = w[k];
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        settings_used++;
    endtask

    // Driver: predicts each accepted transaction and offers the next pending one.
    always @(posedge i_clk) begin : drive_proc
        t_pix_req req;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                if (i_op == OP_STORE) begin
                    frame_model[int'(i_row) * STRIDE + int'(i_col)] = i_pixel_in;
                    stores_done++;
                end else begin
                    expected_pixels.push_back(blur_at(i_row, i_col));
                    filters_done++;
                end
            end
            if (!i_in_valid || o_in_ready) begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    req = pending_reqs.pop_front();
                    i_in_valid <= 1'b1;
                    i_op       <= req.op;
                    i_row      <= req.row;
                    i_col      <= req.col;
                    i_pixel_in <= req.pix;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted result and decides the receiver's readiness.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_left  <= 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                results_checked++;
                if (expected_pixels.size() == 0) begin
                    $display("%0t: unexpected result, filtered %0d", $time, o_filtered);
                    errors++;
                end else if (expected_pixels[0] !== o_filtered) begin
                    $display("%0t: filtered mismatch, expected %0d, actual %0d",
                             $time, expected_pixels[0], o_filtered);
                    errors++;
                    void'(expected_pixels.pop_front());
                end else begin
                    void'(expected_pixels.pop_front());
                end
            end
            if (hold_toggle != hold_seen) begin
                hold_seen   <= hold_toggle;
                stall_left  <= HOLD_CYCLES;
                i_out_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left  <= stall_left - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Stimulus: directed corner cases, then random phases under changing settings.
    initial begin
        int ph, k, t, p, rr, cc, nr, nc, row, col, pix, tr, tc;
        bit full_fill, found;
        logic [8:0] rows, cols;
        logic [2:0] rad;
        logic [15:0] pos;
        t_weights w;

        tx_idle_pct = 14;
        rx_idle_pct = 82;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Corners of the full default frame under the reset weights.
        push_req(OP_STORE, 0, 0, 8'hFF);
        push_req(OP_STORE, 0, 1, 8'h00);
        push_req(OP_STORE, 1, 0, 8'hAA);
        push_req(OP_STORE, 1, 1, 8'h55);
        push_req(OP_STORE, 255, 255, 8'hFF);
        push_req(OP_STORE, 255, 254, 8'h01);
        push_req(OP_STORE, 254, 255, 8'h80);
        push_req(OP_STORE, 254, 254, 8'h7F);
        push_req(OP_FILTER, 0, 0, 8'hFF);
        push_req(OP_FILTER, 255, 255, 8'h00);
        wait_drained();

        // Zero rows acting as one, oversize radius and full weights: the sum saturates.
        configure_block(9'd0, 9'd3, 3'd7, {NUM_WEIGHTS{16'hFFFF}});
        push_req(OP_STORE, 0, 0, 8'hFF);
        push_req(OP_STORE, 0, 1, 8'hFF);
        push_req(OP_STORE, 0, 2, 8'hFF);
        push_req(OP_STORE, 9, 200, 8'h3C);
        push_req(OP_FILTER, 0, 1, 8'h5A);
        push_req(OP_FILTER, 200, 200, 8'hA5);
        push_req(OP_STORE, 0, 1, 8'h00);
        push_req(OP_FILTER, 0, 0, 8'h00);
        wait_drained();

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            tx_idle_pct = (ph < 4) ? 14 : ((ph < 8) ? 82 : 0);
            rx_idle_pct = (ph < 4) ? 82 : ((ph < 8) ? 14 : 0);

            // Pick a setting: small frames mostly, with the extremes in the first phases.
            rows = 9'($urandom_range(1, 16));
            cols = 9'($urandom_range(1, 16));
            if ($urandom_range(7) == 0) begin
                rows = 9'd0;
            end
            if ($urandom_range(7) == 0) begin
                cols = 9'd0;
            end
            rad = 3'($urandom_range(0, 7));
            if ($urandom_range(3) == 0) begin
                for (k = 0; k < NUM_WEIGHTS; k++) begin
                    w[k] = 16'($urandom);
                end
            end else begin
                t = $urandom_range(6000, 40000);
                for (k = 0; k < NUM_WEIGHTS; k++) begin
                    w[k] = 16'(t);
                    t = t * $urandom_range(5, 90) / 100;
                end
            end
            case (ph)
                0: begin
                    rows = 9'd0;
                    cols = 9'd256;
                    rad  = 3'd4;
                    w    = {NUM_WEIGHTS{16'hFFFF}};
                end
                1: begin
                    rows = 9'($urandom_range(257, 511));
                    cols = 9'd1;
                    rad  = 3'd5;
                    w    = '0;
                end
                2: begin
                    rows = 9'd256;
                    cols = 9'd511;
                    rad  = 3'd4;
                    w    = {RST_W4, RST_W3, RST_W2, RST_W1, RST_W0};
                end
                default: begin
                end
            endcase
            configure_block(rows, cols, rad, w);
            nr = eff_size(rows);
            nc = eff_size(cols);

            // Fill the rest of the frame where it is small, else two square patches.
            full_fill = (nr * nc <= 300);
            if (full_fill) begin
                for (rr = 0; rr < nr; rr++) begin
                    for (cc = 0; cc < nc; cc++) begin
                        if (!queued_written[rr * STRIDE + cc]) begin
                            push_req(OP_STORE, rr, cc, $urandom_range(0, 255));
                        end
                    end
                end
            end else begin
                for (p = 0; p < 2; p++) begin
                    tr = (p == 0) ? 244 : $urandom_range(0, 244);
                    tc = (p == 0) ? 244 : $urandom_range(0, 244);
                    if (p == 1) begin
                        tr = 0;
                    end
                    for (rr = 0; rr < 12; rr++) begin
                        for (cc = 0; cc < 12; cc++) begin
                            push_req(OP_STORE, tr + rr, tc + cc, $urandom_range(0, 255));
                        end
                    end
                end
            end

            for (k = 0; k < ITEMS_PER_PHASE; k++) begin
                // Sender pause until every outstanding result has come back.
                if (ph == PAUSE_PHASE && k == ITEMS_PER_PHASE / 2) begin
                    wait_drained();
                end
                pix = $urandom_range(0, 255);
                if ($urandom_range(9) == 0) begin
                    pix = $urandom_range(1) ? 255 : 0;
                end
                if ($urandom_range(99) < 40) begin
                    row = $urandom_range(1) ? $urandom_range(0, nr - 1) : $urandom_range(0, 255);
                    col = $urandom_range(1) ? $urandom_range(0, nc - 1) : $urandom_range(0, 255);
                    push_req(OP_STORE, row, col, pix);
                end else begin
                    found = 1'b0;
                    for (t = 0; t < 16 && !found; t++) begin
                        if (full_fill) begin
                            row = $urandom_range(1) ? $urandom_range(0, nr - 1)
                                                    : $urandom_range(0, 255);
                            col = $urandom_range(1) ? $urandom_range(0, nc - 1)
                                                    : $urandom_range(0, 255);
                        end else begin
                            pos = stored_pos[$urandom_range(0, stored_pos.size() - 1)];
                            row = clamp_pos(int'(pos[15:8]) + $urandom_range(0, 8) - 4, 256);
                            col = clamp_pos(int'(pos[7:0]) + $urandom_range(0, 8) - 4, 256);
                        end
                        found = window_ready(row, col);
                    end
                    if (found) begin
                        push_req(OP_FILTER, row, col, pix);
                    end
                end
            end

            // Long receiver hold-off so that the block fills and stalls its input.
            if (ph == HOLD_PHASE) begin
                hold_toggle = ~hold_toggle;
            end
            wait_drained();
        end

        $display("Covered %0d stores and %0d filter requests over %0d register settings.",
                 stores_done, filters_done, settings_used);
        $display("Frames from one pixel to full size, radius 0 to 7, %0d results checked.",
                 results_checked);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #20000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

>>> sim.f
rtl/gfcb_pkg.sv
rtl/gfcb_frame_mem.sv
rtl/gfcb_seq.sv
rtl/gfcb_mac.sv
rtl/gaussian_filter_clamped_border.sv
rtl/gfcb_checker.sv
sim/gaussian_filter_clamped_border_tb.sv
